// ===== rtl/core/pmcc_pkg.sv =====
// Types and constants for the presence motor contact controller.
// No dependencies; used by presence_motor_contact_controller.
`default_nettype none

package pmcc_pkg;

  // Request on the input channel: one millisecond tick
  typedef struct packed {
    logic               person_present;
    logic signed [15:0] motor_current_ma;
  } in_req_t;

  // Request on the result channel
  typedef struct packed {
    logic [1:0]  ctrl_state;
    logic [1:0]  motor_drive;
    logic        motor_settled;
    logic [15:0] baseline_ma;
  } out_req_t;

  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_CLOSING   = 4'b0010,
    MODE_CONTACT   = 4'b0100,
    MODE_RESETTING = 4'b1000
  } mode_t;

  // Reported state codes
  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_CLOSING   = 2'd1;
  localparam logic [1:0] ST_CONTACT   = 2'd2;
  localparam logic [1:0] ST_RESETTING = 2'd3;

  // Motor drive codes
  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_FWD  = 2'd1;
  localparam logic [1:0] DRV_REV  = 2'd2;

  // Register indexes
  localparam logic [2:0] CFG_CONTACT_OFFSET = 3'd0;
  localparam logic [2:0] CFG_STALL_OFFSET   = 3'd1;
  localparam logic [2:0] CFG_SUSTAIN        = 3'd2;
  localparam logic [2:0] CFG_DETECT_DEB     = 3'd3;
  localparam logic [2:0] CFG_CLEAR_DEB      = 3'd4;
  localparam logic [2:0] CFG_CLOSE_TIMEOUT  = 3'd5;
  localparam logic [2:0] CFG_RESET_DUR      = 3'd6;
  localparam logic [2:0] CFG_SETTLE_NOISE   = 3'd7;

  // Register reset values
  localparam logic [11:0] RST_CONTACT_OFFSET = 12'd130;
  localparam logic [11:0] RST_STALL_OFFSET   = 12'd250;
  localparam logic [15:0] RST_SUSTAIN        = 16'd200;
  localparam logic [15:0] RST_DETECT_DEB     = 16'd500;
  localparam logic [15:0] RST_CLEAR_DEB      = 16'd2000;
  localparam logic [15:0] RST_CLOSE_TIMEOUT  = 16'd10000;
  localparam logic [15:0] RST_RESET_DUR      = 16'd10000;
  localparam logic [9:0]  RST_SETTLE_NOISE   = 10'd30;

  // EMA weights in Q0.16: 0.99 and its complement
  localparam logic [15:0] ALPHA_Q    = 16'd64881;
  localparam logic [9:0]  ALPHA_C_Q  = 10'd655;
  localparam logic [47:0] ROUND_HALF = 48'd32768;

endpackage

`default_nettype wire

// ===== rtl/core/presence_motor_contact_controller.sv =====
// Presence motor contact controller: top level, one module.
// Depends on pmcc_pkg for request types, mode enum and codes.
//
//   channel | ports                          | moves
//   --------+--------------------------------+------------------------------
//   input   | in_valid, in_stall, in_req     | one tick: presence, current
//   result  | out_valid, out_stall, out_req  | state, drive, settled, baseline
//   config  | cfg_we, cfg_idx, cfg_wdata     | register write, no read-back
//
// One request per clock while the result is not stalled: input register, update logic, result register.
// The result is registered from the input register once the result side is not stalled.
// The path is set by the baseline EMA multiply (32 x 16) into the baseline register.
// Reset is synchronous, active low; it clears control state and loads register defaults.
// A stalled result holds; the input register still takes one more request behind it.
`default_nettype none

module presence_motor_contact_controller #(
  parameter int COUNT_WIDTH       = 16,
  parameter int SAMPLE_PERIOD_MS  = 100,
  parameter int STABLE_HOLD_MS    = 150,
  parameter int SETTLE_TIMEOUT_MS = 3000
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pmcc_pkg::in_req_t  in_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pmcc_pkg::out_req_t      out_req,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [15:0]        cfg_wdata
);

  localparam int CW   = COUNT_WIDTH;
  localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  // configuration
  logic [11:0] contact_off_r, stall_off_r;
  logic [15:0] sustain_r, detect_deb_r, clear_deb_r, close_to_r, reset_dur_r;
  logic [9:0]  noise_r;

  // pipeline
  logic               in_vld_r, out_vld_r;
  pmcc_pkg::in_req_t  in_r;
  pmcc_pkg::out_req_t out_r;
  logic               adv, fire;

  // controller state
  pmcc_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]      drive_r, drive_nxt;
  logic            prev_r, prev_nxt;
  logic [CW-1:0]   pa_r, pa_nxt, aa_r, aa_nxt, tim_r, tim_nxt;
  logic            over_act_r, over_act_nxt;
  logic [CW-1:0]   over_age_r, over_age_nxt;
  logic            settled_r, settled_nxt;
  logic            sv_r, sv_nxt;
  logic [7:0]      sage_r, sage_nxt;
  logic [15:0]     prev_smp_r, prev_smp_nxt;
  logic            stab_act_r, stab_act_nxt;
  logic [CW-1:0]   stab_age_r, stab_age_nxt;
  logic [31:0]     base_r, base_nxt;

  assign adv       = !out_vld_r || !out_stall;
  assign fire      = in_vld_r && adv;
  assign in_stall  = in_vld_r && !adv;
  assign out_valid = out_vld_r;
  assign out_req   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contact_off_r <= pmcc_pkg::RST_CONTACT_OFFSET;
      stall_off_r   <= pmcc_pkg::RST_STALL_OFFSET;
      sustain_r     <= pmcc_pkg::RST_SUSTAIN;
      detect_deb_r  <= pmcc_pkg::RST_DETECT_DEB;
      clear_deb_r   <= pmcc_pkg::RST_CLEAR_DEB;
      close_to_r    <= pmcc_pkg::RST_CLOSE_TIMEOUT;
      reset_dur_r   <= pmcc_pkg::RST_RESET_DUR;
      noise_r       <= pmcc_pkg::RST_SETTLE_NOISE;
    end else if (cfg_we) begin
      case (cfg_idx)
        pmcc_pkg::CFG_CONTACT_OFFSET: contact_off_r <= cfg_wdata[11:0];
        pmcc_pkg::CFG_STALL_OFFSET:   stall_off_r   <= cfg_wdata[11:0];
        pmcc_pkg::CFG_SUSTAIN:        sustain_r     <= cfg_wdata;
        pmcc_pkg::CFG_DETECT_DEB:     detect_deb_r  <= cfg_wdata;
        pmcc_pkg::CFG_CLEAR_DEB:      clear_deb_r   <= cfg_wdata;
        pmcc_pkg::CFG_CLOSE_TIMEOUT:  close_to_r    <= cfg_wdata;
        pmcc_pkg::CFG_RESET_DUR:      reset_dur_r   <= cfg_wdata;
        pmcc_pkg::CFG_SETTLE_NOISE:   noise_r       <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // handshake control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_req;
    end
    if (fire) begin
      case (mode_nxt)
        pmcc_pkg::MODE_CLOSING:   out_r.ctrl_state <= pmcc_pkg::ST_CLOSING;
        pmcc_pkg::MODE_CONTACT:   out_r.ctrl_state <= pmcc_pkg::ST_CONTACT;
        pmcc_pkg::MODE_RESETTING: out_r.ctrl_state <= pmcc_pkg::ST_RESETTING;
        default:                  out_r.ctrl_state <= pmcc_pkg::ST_IDLE;
      endcase
      out_r.motor_drive   <= drive_nxt;
      out_r.motor_settled <= settled_nxt;
      out_r.baseline_ma   <= base_nxt[31:16];
    end
  end

  // per-tick update
  always_comb begin
    logic        present;
    logic [15:0] raw;
    logic [15:0] mag;
    logic        cleared;
    logic        due;
    logic        falling;
    logic        stop;
    logic        run_mon;
    logic        enter;
    logic [11:0] offset;
    logic [32:0] thresh;
    logic [47:0] ema_sum;

    present = in_r.person_present;
    raw     = in_r.motor_current_ma;
    mag     = raw[15] ? (~raw + 16'd1) : raw;

    mode_nxt     = mode_r;
    drive_nxt    = drive_r;
    over_act_nxt = over_act_r;
    settled_nxt  = settled_r;
    sv_nxt       = sv_r;
    prev_smp_nxt = prev_smp_r;
    stab_act_nxt = stab_act_r;
    base_nxt     = base_r;
    stop         = 1'b0;
    enter        = 1'b0;

    // advance the saturating timers
    tim_nxt      = (&tim_r) ? tim_r : tim_r + 1'b1;
    pa_nxt       = (&pa_r) ? pa_r : pa_r + 1'b1;
    aa_nxt       = (&aa_r) ? aa_r : aa_r + 1'b1;
    sage_nxt     = (sv_r && !(&sage_r)) ? sage_r + 8'd1 : sage_r;
    stab_age_nxt = (stab_act_r && !(&stab_age_r)) ? stab_age_r + 1'b1 : stab_age_r;
    over_age_nxt = (over_act_r && !(&over_age_r)) ? over_age_r + 1'b1 : over_age_r;

    if (present && !prev_r) begin
      pa_nxt = '0;
    end
    if (!present && prev_r) begin
      aa_nxt = '0;
    end
    prev_nxt = present;

    cleared = !present && (CMPW'(aa_nxt) >= CMPW'(clear_deb_r));

    // settle detector and overcurrent watch, used while driving
    run_mon = (mode_r == pmcc_pkg::MODE_CLOSING) || (mode_r == pmcc_pkg::MODE_RESETTING);
    offset  = (mode_r == pmcc_pkg::MODE_CLOSING) ? contact_off_r : stall_off_r;
    due     = !sv_r || (sage_nxt >= 8'(SAMPLE_PERIOD_MS));
    falling = {1'b0, prev_smp_r} > (17'(mag) + 17'(noise_r));
    thresh  = {1'b0, base_r} + {5'd0, offset, 16'd0};
    ema_sum = 48'(base_r) * 48'(pmcc_pkg::ALPHA_Q)
            + {6'd0, 26'(mag) * 26'(pmcc_pkg::ALPHA_C_Q), 16'd0}
            + pmcc_pkg::ROUND_HALF;

    if (run_mon) begin
      if (!settled_r) begin
        if (due) begin
          if (sv_r) begin
            if (falling) begin
              stab_act_nxt = 1'b0;
            end else begin
              if (!stab_act_r) begin
                stab_act_nxt = 1'b1;
                stab_age_nxt = '0;
              end
              if (CMPW'(stab_age_nxt) >= CMPW'(STABLE_HOLD_MS)) begin
                settled_nxt = 1'b1;
                base_nxt    = {mag, 16'd0};
              end
            end
          end
          prev_smp_nxt = mag;
          sv_nxt       = 1'b1;
          sage_nxt     = 8'd0;
        end
        if (CMPW'(tim_nxt) >= CMPW'(SETTLE_TIMEOUT_MS)) begin
          settled_nxt = 1'b1;
          base_nxt    = {prev_smp_nxt, 16'd0};
        end
      end else if (due) begin
        if ({1'b0, mag, 16'd0} > thresh) begin
          if (!over_act_r) begin
            over_act_nxt = 1'b1;
            over_age_nxt = '0;
          end
          if (CMPW'(over_age_nxt) >= CMPW'(sustain_r)) begin
            stop = 1'b1;
          end
        end else begin
          over_act_nxt = 1'b0;
          base_nxt     = ema_sum[47:16];
        end
        sv_nxt   = 1'b1;
        sage_nxt = 8'd0;
      end
    end

    case (mode_r)
      pmcc_pkg::MODE_IDLE: begin
        if (present && (CMPW'(pa_nxt) >= CMPW'(detect_deb_r))) begin
          drive_nxt = pmcc_pkg::DRV_FWD;
          mode_nxt  = pmcc_pkg::MODE_CLOSING;
          enter     = 1'b1;
        end
      end
      pmcc_pkg::MODE_CLOSING: begin
        if (stop) begin
          drive_nxt = pmcc_pkg::DRV_STOP;
          mode_nxt  = pmcc_pkg::MODE_CONTACT;
          enter     = 1'b1;
        end else begin
          if (CMPW'(tim_nxt) >= CMPW'(close_to_r)) begin
            drive_nxt = pmcc_pkg::DRV_STOP;
            mode_nxt  = pmcc_pkg::MODE_CONTACT;
            enter     = 1'b1;
          end
          // a debounced clear overrides the timeout within the same tick
          if (cleared) begin
            drive_nxt = pmcc_pkg::DRV_REV;
            mode_nxt  = pmcc_pkg::MODE_RESETTING;
            enter     = 1'b1;
          end
        end
      end
      pmcc_pkg::MODE_CONTACT: begin
        if (cleared) begin
          drive_nxt = pmcc_pkg::DRV_REV;
          mode_nxt  = pmcc_pkg::MODE_RESETTING;
          enter     = 1'b1;
        end
      end
      pmcc_pkg::MODE_RESETTING: begin
        if (stop || (CMPW'(tim_nxt) >= CMPW'(reset_dur_r))) begin
          drive_nxt = pmcc_pkg::DRV_STOP;
          mode_nxt  = pmcc_pkg::MODE_IDLE;
          enter     = 1'b1;
        end
      end
      default: begin
        drive_nxt = pmcc_pkg::DRV_STOP;
        mode_nxt  = pmcc_pkg::MODE_IDLE;
        enter     = 1'b1;
      end
    endcase

    // a new mode starts with fresh timing, settle and baseline state
    if (enter) begin
      tim_nxt      = '0;
      over_act_nxt = 1'b0;
      over_age_nxt = '0;
      settled_nxt  = 1'b0;
      sv_nxt       = 1'b0;
      sage_nxt     = 8'd0;
      prev_smp_nxt = 16'd0;
      stab_act_nxt = 1'b0;
      stab_age_nxt = '0;
      base_nxt     = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= pmcc_pkg::MODE_IDLE;
      drive_r    <= pmcc_pkg::DRV_STOP;
      prev_r     <= 1'b0;
      pa_r       <= '1;
      aa_r       <= '1;
      tim_r      <= '0;
      over_act_r <= 1'b0;
      over_age_r <= '0;
      settled_r  <= 1'b0;
      sv_r       <= 1'b0;
      sage_r     <= 8'd0;
      prev_smp_r <= 16'd0;
      stab_act_r <= 1'b0;
      stab_age_r <= '0;
      base_r     <= 32'd0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      drive_r    <= drive_nxt;
      prev_r     <= prev_nxt;
      pa_r       <= pa_nxt;
      aa_r       <= aa_nxt;
      tim_r      <= tim_nxt;
      over_act_r <= over_act_nxt;
      over_age_r <= over_age_nxt;
      settled_r  <= settled_nxt;
      sv_r       <= sv_nxt;
      sage_r     <= sage_nxt;
      prev_smp_r <= prev_smp_nxt;
      stab_act_r <= stab_act_nxt;
      stab_age_r <= stab_age_nxt;
      base_r     <= base_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fwd_only_closing: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == pmcc_pkg::MODE_CLOSING) == (drive_r == pmcc_pkg::DRV_FWD))
    else $error("forward drive outside closing");

  a_rev_only_resetting: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == pmcc_pkg::MODE_RESETTING) == (drive_r == pmcc_pkg::DRV_REV))
    else $error("reverse drive outside resetting");

  a_base_zero_unsettled: assert property (@(posedge clk) disable iff (!rst_n)
    !settled_r |-> (base_r == 32'd0))
    else $error("baseline set before settling");

  a_mode_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (mode_nxt != mode_r) |=> (tim_r == '0) && !settled_r && !over_act_r)
    else $error("mode change left timing state behind");

  a_result_follows_update: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r && (out_r.motor_drive == drive_r))
    else $error("result does not match updated state");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for presence_motor_contact_controller: sends millisecond tick requests,
// predicts every state report and checks it against the result channel.
// Depends on pmcc_pkg and the block itself.
module testbench;
  import pmcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SAMPLE_PERIOD  = 100;
  localparam int STABLE_MS      = 150;
  localparam int SETTLE_TIMEOUT = 3000;
  localparam int TOTAL_TICKS    = 1250;
  localparam int CALM_FROM      = 1100;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Tracks the controller state and queues the report each tick request should give
  class report_tracker;
    logic [11:0] contact_off, stall_off;
    logic [15:0] sustain, detect_deb, clear_deb, close_to, reset_dur;
    logic [9:0]  noise;
    mode_t       mode;
    logic [1:0]  drive;
    bit          prev_present;
    logic [15:0] present_age, absent_age, mode_age, over_age, stable_age;
    bit          over_on, settled, sample_on, stable_on;
    logic [7:0]  sample_age;
    int unsigned prev_mag;
    logic [31:0] baseline_q;
    out_req_t    expected_reports[$];
    int          errors;
    int          checked;

    function new();
      contact_off  = RST_CONTACT_OFFSET;
      stall_off    = RST_STALL_OFFSET;
      sustain      = RST_SUSTAIN;
      detect_deb   = RST_DETECT_DEB;
      clear_deb    = RST_CLEAR_DEB;
      close_to     = RST_CLOSE_TIMEOUT;
      reset_dur    = RST_RESET_DUR;
      noise        = RST_SETTLE_NOISE;
      enter(MODE_IDLE);
      drive        = DRV_STOP;
      prev_present = 1'b0;
      present_age  = COUNT_MAX;
      absent_age   = COUNT_MAX;
      errors       = 0;
      checked      = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_CONTACT_OFFSET: contact_off = data[11:0];
        CFG_STALL_OFFSET:   stall_off   = data[11:0];
        CFG_SUSTAIN:        sustain     = data;
        CFG_DETECT_DEB:     detect_deb  = data;
        CFG_CLEAR_DEB:      clear_deb   = data;
        CFG_CLOSE_TIMEOUT:  close_to    = data;
        CFG_RESET_DUR:      reset_dur   = data;
        CFG_SETTLE_NOISE:   noise       = data[9:0];
        default: ;
      endcase
    endfunction

    function void enter(mode_t m);
      mode       = m;
      mode_age   = '0;
      over_on    = 1'b0;
      over_age   = '0;
      settled    = 1'b0;
      sample_on  = 1'b0;
      sample_age = '0;
      prev_mag   = 0;
      stable_on  = 1'b0;
      stable_age = '0;
      baseline_q = '0;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == COUNT_MAX) ? v : v + 16'd1;
    endfunction

    // Settle watch first, then overcurrent against the baseline; 1 means stop the motor
    function bit watch_drive(int unsigned mag, logic [11:0] offset);
      bit due;
      longint unsigned thresh;
      due = !sample_on || sample_age >= SAMPLE_PERIOD;
      if (!settled) begin
        if (due) begin
          if (sample_on) begin
            if (prev_mag > mag + noise) begin
              stable_on = 1'b0;
            end else begin
              if (!stable_on) begin
                stable_on  = 1'b1;
                stable_age = '0;
              end
              if (stable_age >= STABLE_MS) begin
                settled    = 1'b1;
                baseline_q = mag << 16;
              end
            end
          end
          prev_mag   = mag;
          sample_on  = 1'b1;
          sample_age = '0;
        end
        if (mode_age >= SETTLE_TIMEOUT) begin
          settled    = 1'b1;
          baseline_q = prev_mag << 16;
        end
        return 1'b0;
      end
      if (due) begin
        thresh = 64'(baseline_q) + (64'(offset) << 16);
        if ((64'(mag) << 16) > thresh) begin
          if (!over_on) begin
            over_on  = 1'b1;
            over_age = '0;
          end
          if (over_age >= sustain) return 1'b1;
        end else begin
          over_on    = 1'b0;
          baseline_q = 32'((64'(baseline_q) * 64'(ALPHA_Q)
                          + (64'(mag) << 16) * 64'(ALPHA_C_Q) + 64'(ROUND_HALF)) >> 16);
        end
        sample_on  = 1'b1;
        sample_age = '0;
      end
      return 1'b0;
    endfunction

    function void take_tick(in_req_t r);
      bit          present, cleared;
      int unsigned mag;
      logic [15:0] elapsed;
      out_req_t    rep;
      present = r.person_present;
      mag = r.motor_current_ma[15] ? 32'h10000 - 32'(r.motor_current_ma[15:0])
                                   : 32'(r.motor_current_ma[15:0]);

      mode_age    = bump(mode_age);
      present_age = bump(present_age);
      absent_age  = bump(absent_age);
      if (sample_on && sample_age < 8'd255) sample_age = sample_age + 8'd1;
      if (stable_on) stable_age = bump(stable_age);
      if (over_on) over_age = bump(over_age);

      if (present && !prev_present) present_age = '0;
      if (!present && prev_present) absent_age = '0;
      prev_present = present;

      elapsed = mode_age;
      cleared = !present && absent_age >= clear_deb;
      case (mode)
        MODE_IDLE: begin
          if (present && present_age >= detect_deb) begin
            drive = DRV_FWD;
            enter(MODE_CLOSING);
          end
        end
        MODE_CLOSING: begin
          if (watch_drive(mag, contact_off)) begin
            drive = DRV_STOP;
            enter(MODE_CONTACT);
          end else begin
            if (elapsed >= close_to) begin
              drive = DRV_STOP;
              enter(MODE_CONTACT);
            end
            // a debounced clear overrides the timeout in the same tick
            if (cleared) begin
              drive = DRV_REV;
              enter(MODE_RESETTING);
            end
          end
        end
        MODE_CONTACT: begin
          if (cleared) begin
            drive = DRV_REV;
            enter(MODE_RESETTING);
          end
        end
        default: begin
          if (watch_drive(mag, stall_off) || elapsed >= reset_dur) begin
            drive = DRV_STOP;
            enter(MODE_IDLE);
          end
        end
      endcase

      case (mode)
        MODE_IDLE:    rep.ctrl_state = ST_IDLE;
        MODE_CLOSING: rep.ctrl_state = ST_CLOSING;
        MODE_CONTACT: rep.ctrl_state = ST_CONTACT;
        default:      rep.ctrl_state = ST_RESETTING;
      endcase
      rep.motor_drive   = drive;
      rep.motor_settled = settled;
      rep.baseline_ma   = baseline_q[31:16];
      expected_reports.push_back(rep);
    endfunction

    function void flag_error(string what, out_req_t want, out_req_t got);
      errors++;
      if (errors <= 10)
        $display("report %0d %s: expected state %0d drive %0d settled %0d baseline %0d, got state %0d drive %0d settled %0d baseline %0d",
                 checked, what, want.ctrl_state, want.motor_drive, want.motor_settled,
                 want.baseline_ma, got.ctrl_state, got.motor_drive, got.motor_settled,
                 got.baseline_ma);
    endfunction

    function void check_report(out_req_t got);
      out_req_t want;
      checked++;
      if (expected_reports.size() == 0) begin
        flag_error("with no tick pending", '0, got);
        return;
      end
      want = expected_reports.pop_front();
      if (got.ctrl_state !== want.ctrl_state || got.motor_drive !== want.motor_drive ||
          got.motor_settled !== want.motor_settled || got.baseline_ma !== want.baseline_ma)
        flag_error("mismatch", want, got);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_req;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  report_tracker tracker;
  bit          calm = 1'b0;
  int          gap_pct = 10;
  int          hold_pct = 3;
  int          quiet_cycles = 0;
  int unsigned base_ma = 500;
  int unsigned spike_delay = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  presence_motor_contact_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  function automatic in_req_t fixed_tick(bit p, logic signed [15:0] c);
    in_req_t r;
    r.person_present   = p;
    r.motor_current_ma = c;
    return r;
  endfunction

  // Follow the predicted mode so most ticks form a believable drive cycle
  function automatic in_req_t make_tick();
    in_req_t     r;
    int unsigned mag, t;
    logic [11:0] off;
    if ($urandom_range(99) < 6) begin
      r.person_present   = 1'($urandom);
      r.motor_current_ma = 16'($urandom);
      return r;
    end
    t = tracker.mode_age;
    case (tracker.mode)
      MODE_IDLE: begin
        r.person_present = ($urandom_range(19) != 0);
        mag = $urandom_range(200);
      end
      MODE_CONTACT: begin
        r.person_present = ($urandom_range(19) == 0);
        mag = $urandom_range(200);
      end
      default: begin
        if (tracker.mode == MODE_CLOSING) begin
          off = tracker.contact_off;
          r.person_present = ($urandom_range(49) != 0);
        end else begin
          off = tracker.stall_off;
          r.person_present = ($urandom_range(49) == 0);
        end
        if (t < 250)
          mag = base_ma + 8 * (250 - t) + $urandom_range(20);
        else if (tracker.settled && t >= 300 + spike_delay)
          mag = base_ma + off + $urandom_range(1500);
        else
          mag = base_ma + $urandom_range(20);
      end
    endcase
    if (mag > 32767) mag = 32767;
    r.motor_current_ma = $urandom_range(1) ? 16'(-mag) : 16'(mag);
    return r;
  endfunction

  function automatic logic [11:0] pick_offset();
    return ($urandom_range(9) == 0) ? 12'd4095 : 12'($urandom_range(600, 1));
  endfunction

  function automatic logic [15:0] pick_timeout();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 3) return 16'($urandom_range(400));
    if (k < 7) return 16'($urandom_range(2000, 400));
    return (k == 9) ? COUNT_MAX : 16'($urandom_range(65535, 2000));
  endfunction

  function automatic logic [15:0] pick_debounce();
    return ($urandom_range(9) == 0) ? 16'($urandom_range(300)) : 16'($urandom_range(20));
  endfunction

  task automatic send_tick(in_req_t r);
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    tracker.take_tick(r);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic load_regs(input logic [15:0] v [8]);
    for (int i = CFG_CONTACT_OFFSET; i <= CFG_SETTLE_NOISE; i++)
      set_reg(3'(i), v[i]);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every report is back and the pipeline is empty
  task automatic drain();
    while (tracker.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [15:0] v [8];
    int total, len;
    tracker   = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_CONTACT_OFFSET;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values with current extremes
    send_tick(fixed_tick(1'b1, 16'sh8000));
    send_tick(fixed_tick(1'b0, 16'sh7FFF));
    send_tick(fixed_tick(1'b1, 16'sh0000));
    send_tick(fixed_tick(1'b0, 16'shFFFF));
    in_valid <= 1'b0;
    drain();

    // zero debounces and timeouts; upper write bits must be dropped
    v[CFG_CONTACT_OFFSET] = 16'hF001;
    v[CFG_STALL_OFFSET]   = 16'h7001;
    v[CFG_SUSTAIN]        = 16'h0000;
    v[CFG_DETECT_DEB]     = 16'h0000;
    v[CFG_CLEAR_DEB]      = 16'h0000;
    v[CFG_CLOSE_TIMEOUT]  = 16'h0000;
    v[CFG_RESET_DUR]      = 16'h0000;
    v[CFG_SETTLE_NOISE]   = 16'hFC00;
    load_regs(v);
    send_tick(fixed_tick(1'b0, 16'sd0));
    send_tick(fixed_tick(1'b1, 16'sd100));
    send_tick(fixed_tick(1'b1, 16'sh8000));
    send_tick(fixed_tick(1'b1, 16'sd0));
    send_tick(fixed_tick(1'b0, 16'sd5));
    send_tick(fixed_tick(1'b0, 16'sh8000));
    send_tick(fixed_tick(1'b1, 16'sd1));
    // close timeout and debounced clear in the same tick
    send_tick(fixed_tick(1'b0, 16'sh7FFF));
    send_tick(fixed_tick(1'b0, 16'sd0));
    send_tick(fixed_tick(1'b0, -16'sd1));
    in_valid <= 1'b0;
    drain();

    for (int i = CFG_CONTACT_OFFSET; i <= CFG_SETTLE_NOISE; i++) v[i] = COUNT_MAX;
    load_regs(v);
    send_tick(fixed_tick(1'b1, 16'sh7FFF));
    send_tick(fixed_tick(1'b1, 16'sh8000));
    send_tick(fixed_tick(1'b0, 16'sd0));
    send_tick(fixed_tick(1'b1, -16'sd1));
    in_valid <= 1'b0;

    total = 0;
    while (total < TOTAL_TICKS) begin
      drain();
      v[CFG_CONTACT_OFFSET] = {4'($urandom), pick_offset()};
      v[CFG_STALL_OFFSET]   = {4'($urandom), pick_offset()};
      case ($urandom_range(9))
        0:       v[CFG_SUSTAIN] = 16'd0;
        1:       v[CFG_SUSTAIN] = COUNT_MAX;
        default: v[CFG_SUSTAIN] = 16'($urandom_range(300));
      endcase
      v[CFG_DETECT_DEB]     = pick_debounce();
      v[CFG_CLEAR_DEB]      = pick_debounce();
      v[CFG_CLOSE_TIMEOUT]  = pick_timeout();
      v[CFG_RESET_DUR]      = pick_timeout();
      v[CFG_SETTLE_NOISE]   = {6'($urandom),
                               ($urandom_range(7) == 0) ? 10'd1023 : 10'($urandom_range(100))};
      load_regs(v);
      base_ma     = $urandom_range(3000, 50);
      spike_delay = $urandom_range(300);
      case ($urandom_range(2))
        0:       begin gap_pct = 0;  hold_pct = 0;  end
        1:       begin gap_pct = 5;  hold_pct = 2;  end
        default: begin gap_pct = 20; hold_pct = 8;  end
      endcase
      len = $urandom_range(500, 200);
      if (total + len > TOTAL_TICKS) len = TOTAL_TICKS - total;
      for (int i = 0; i < len; i++) begin
        calm = (total >= CALM_FROM);
        send_tick(make_tick());
        total++;
      end
      in_valid <= 1'b0;
    end

    while (tracker.expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side back-pressure in bursts
  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(99) < hold_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(19, 1)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_report(out_req);
  end

  // Abort when neither channel moves a request for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
